[sv/s27g_pkg.sv]
// package for the 27-point stencil sparse row generator
// widths, value codes, register indexes and the remainder unit status type
// no dependencies
package s27g_pkg;

    // field widths fixed by the interface
    localparam int DIM_W   = 7;
    localparam int CS_W    = 19;
    localparam int ROW_W   = 3 * DIM_W;
    localparam int PLANE_W = 2 * DIM_W;
    localparam int IDX_W   = 18;
    localparam int OFF_W   = 23;
    localparam int CHK_W   = 19;
    localparam int NZ_W    = 5;
    localparam int VAL_W   = 6;
    localparam int REM_CNT_W = $clog2(ROW_W);

    // register indexes
    localparam logic [1:0] REG_GRID_X     = 2'd0;
    localparam logic [1:0] REG_GRID_Y     = 2'd1;
    localparam logic [1:0] REG_GRID_Z     = 2'd2;
    localparam logic [1:0] REG_CHUNK_SIZE = 2'd3;

    // register reset values
    localparam logic [DIM_W-1:0] GRID_RST  = 7'd16;
    localparam logic [CS_W-1:0]  CHUNK_RST = 19'd1024;

    // matrix values
    localparam logic signed [VAL_W-1:0] VAL_DIAG = 6'sd26;
    localparam logic signed [VAL_W-1:0] VAL_OFF  = -6'sd1;

    // status from the remainder unit
    typedef struct packed {
        logic done;
        logic zero;
    } rem_stat_t;

endpackage

[sv/s27g_rem.sv]
// iterative remainder unit: row index modulo chunk size, one bit per cycle
// depends on s27g_pkg
module s27g_rem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [s27g_pkg::ROW_W-1:0]  dividend,
    input  logic [s27g_pkg::CS_W-1:0]   divisor,
    output s27g_pkg::rem_stat_t         stat
);
    import s27g_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ROW_W-1:0]     dvd_reg, dvd_next;
    logic [CS_W-1:0]      rem_reg, rem_next;
    logic [CS_W:0]        trial;
    logic                 fits;

    // one restoring step
    assign trial = {rem_reg, dvd_reg[ROW_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = REM_CNT_W'(ROW_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[ROW_W-2:0], 1'b0};
            rem_next = fits ? CS_W'(trial - {1'b0, divisor}) : trial[CS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

[sv/stencil_27pt_sparse_row_generator_unit.sv]
// top level of the 27-point stencil sparse row generator
// depends on s27g_pkg and s27g_rem
//
// channel   signals                         direction  meaning
// req       req_valid/req_ready, restart    in         one transaction per matrix row
// ent       ent_valid/ent_ready, 9 fields   out        one transaction per stencil entry
// cfg       cfg_we, cfg_index, cfg_data     in         register write, no wait
//
// a row takes a setup phase (three passes through the shared multiplier,
// a column base step and a bit-serial remainder over the 21-bit row index for
// the chunk test), then one cycle per entry (1 to 27 entries) and the idle
// state that takes the next transaction.
// reset returns the cursor to row 0, clears the counters and loads the register
// defaults. a stalled ent_ready holds the entry walk; req_ready is high only
// while no row is in progress.
module stencil_27pt_sparse_row_generator_unit #(
    parameter int MAX_DIM = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [s27g_pkg::CS_W-1:0]           cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                restart,
    output logic                                ent_valid,
    input  logic                                ent_ready,
    output logic [s27g_pkg::IDX_W-1:0]          row_index,
    output logic [s27g_pkg::IDX_W-1:0]          column_index,
    output logic signed [s27g_pkg::VAL_W-1:0]   entry_value,
    output logic [s27g_pkg::OFF_W-1:0]          entry_offset,
    output logic                                chunk_start,
    output logic [s27g_pkg::IDX_W-1:0]          chunk_number,
    output logic [s27g_pkg::NZ_W-1:0]           row_nonzeros,
    output logic                                last_in_row,
    output logic                                grid_done
);
    import s27g_pkg::*;

    localparam int DIM_CAP = (MAX_DIM > 127) ? 127 : MAX_DIM;
    localparam int CUR_W   = $clog2(DIM_CAP);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NYNZ = 3'd1;
    localparam logic [2:0] S_ROWX = 3'd2;
    localparam logic [2:0] S_ROWY = 3'd3;
    localparam logic [2:0] S_COL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    // configuration registers
    logic [DIM_W-1:0] gx_reg, gy_reg, gz_reg;
    logic [CS_W-1:0]  cs_reg;

    // sequencer and walk state
    logic [2:0]         state_reg, state_next;
    logic [CUR_W-1:0]   rx_reg, rx_next, ry_reg, ry_next, rz_reg, rz_next;
    logic [CUR_W-1:0]   cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [CHK_W-1:0]   chk_reg, chk_next;
    logic [PLANE_W-1:0] nynz_reg, nynz_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ROW_W-1:0]   col_reg, col_next, colx_reg, colx_next, coly_reg, coly_next;
    logic [NZ_W-1:0]    k_reg, k_next;
    logic               starts_reg, starts_next;

    // output register
    logic                    ov_reg, ov_next;
    logic [IDX_W-1:0]        o_row_reg, o_row_next, o_col_reg, o_col_next;
    logic signed [VAL_W-1:0] o_val_reg, o_val_next;
    logic [OFF_W-1:0]        o_off_reg, o_off_next;
    logic                    o_cs_reg, o_cs_next;
    logic [IDX_W-1:0]        o_cn_reg, o_cn_next;
    logic [NZ_W-1:0]         o_nz_reg, o_nz_next;
    logic                    o_last_reg, o_last_next, o_done_reg, o_done_next;

    logic [DIM_W-1:0]   nx, ny, nz;
    logic [CS_W-1:0]    cs;
    logic [DIM_W-1:0]   x0, x1, y0, y1, z0, z1;
    logic [DIM_W-1:0]   mul_a;
    logic [PLANE_W-1:0] mul_b;
    logic [ROW_W-1:0]   prod;
    logic               accept, load, last_row, out_of_grid, end_x, end_y, end_z;
    rem_stat_t          rstat;

    // effective dimensions and chunk size
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > DIM_CAP)
            r = DIM_W'(DIM_CAP);
        return r;
    endfunction

    assign nx = clamp_dim(gx_reg);
    assign ny = clamp_dim(gy_reg);
    assign nz = clamp_dim(gz_reg);
    assign cs = (cs_reg == '0) ? CS_W'(1) : cs_reg;

    // stencil bounds around the current row
    assign x0 = (rx_reg != '0) ? DIM_W'(rx_reg) - 1'b1 : '0;
    assign y0 = (ry_reg != '0) ? DIM_W'(ry_reg) - 1'b1 : '0;
    assign z0 = (rz_reg != '0) ? DIM_W'(rz_reg) - 1'b1 : '0;
    assign x1 = (DIM_W'(rx_reg) + 1'b1 < nx) ? DIM_W'(rx_reg) + 1'b1 : nx - 1'b1;
    assign y1 = (DIM_W'(ry_reg) + 1'b1 < ny) ? DIM_W'(ry_reg) + 1'b1 : ny - 1'b1;
    assign z1 = (DIM_W'(rz_reg) + 1'b1 < nz) ? DIM_W'(rz_reg) + 1'b1 : nz - 1'b1;

    assign last_row = (DIM_W'(rx_reg) == nx - 1'b1) && (DIM_W'(ry_reg) == ny - 1'b1)
                   && (DIM_W'(rz_reg) == nz - 1'b1);
    assign out_of_grid = (DIM_W'(rx_reg) >= nx) || (DIM_W'(ry_reg) >= ny)
                      || (DIM_W'(rz_reg) >= nz);

    assign end_z = (DIM_W'(cz_reg) == z1);
    assign end_y = (DIM_W'(cy_reg) == y1);
    assign end_x = (DIM_W'(cx_reg) == x1);

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign load      = (state_reg == S_EMIT) && (!ov_reg || ent_ready);

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            S_NYNZ:
            begin
                mul_a = ny;
                mul_b = PLANE_W'(nz);
            end
            S_ROWX:
            begin
                mul_a = DIM_W'(rx_reg);
                mul_b = nynz_reg;
            end
            default:
            begin
                mul_a = DIM_W'(ry_reg);
                mul_b = PLANE_W'(nz);
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // remainder unit for the chunk test
    s27g_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_COL),
        .dividend (row_reg),
        .divisor  (cs),
        .stat     (rstat)
    );

    // sequencer and entry walk
    always_comb
    begin
        state_next  = state_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        rz_next     = rz_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        off_next    = off_reg;
        chk_next    = chk_reg;
        nynz_next   = nynz_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        colx_next   = colx_reg;
        coly_next   = coly_reg;
        k_next      = k_reg;
        starts_next = starts_reg;
        ov_next     = ov_reg && !ent_ready;
        o_row_next  = o_row_reg;
        o_col_next  = o_col_reg;
        o_val_next  = o_val_reg;
        o_off_next  = o_off_reg;
        o_cs_next   = o_cs_reg;
        o_cn_next   = o_cn_reg;
        o_nz_next   = o_nz_reg;
        o_last_next = o_last_reg;
        o_done_next = o_done_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (restart || out_of_grid)
                    begin
                        rx_next  = '0;
                        ry_next  = '0;
                        rz_next  = '0;
                        off_next = '0;
                        chk_next = '0;
                    end
                    state_next = S_NYNZ;
                end
            end
            S_NYNZ:
            begin
                nynz_next  = prod[PLANE_W-1:0];
                state_next = S_ROWX;
            end
            S_ROWX:
            begin
                row_next   = prod;
                state_next = S_ROWY;
            end
            S_ROWY:
            begin
                row_next   = row_reg + prod + ROW_W'(rz_reg);
                state_next = S_COL;
            end
            S_COL:
            begin
                // column of the first neighbour
                col_next = row_reg
                         - ((rx_reg != '0) ? ROW_W'(nynz_reg) : '0)
                         - ((ry_reg != '0) ? ROW_W'(nz) : '0)
                         - ((rz_reg != '0) ? ROW_W'(1) : '0);
                colx_next  = col_next;
                coly_next  = col_next;
                cx_next    = CUR_W'(x0);
                cy_next    = CUR_W'(y0);
                cz_next    = CUR_W'(z0);
                k_next     = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (rstat.done)
                begin
                    starts_next = rstat.zero;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    ov_next     = 1'b1;
                    o_row_next  = row_reg[IDX_W-1:0];
                    o_col_next  = col_reg[IDX_W-1:0];
                    o_val_next  = (cx_reg == rx_reg && cy_reg == ry_reg && cz_reg == rz_reg)
                                ? VAL_DIAG : VAL_OFF;
                    o_off_next  = off_reg;
                    o_cs_next   = (k_reg == '0) && starts_reg;
                    o_cn_next   = ((k_reg == '0) && starts_reg) ? chk_reg[IDX_W-1:0] : '0;
                    o_last_next = end_x && end_y && end_z;
                    o_nz_next   = o_last_next ? k_reg + 1'b1 : '0;
                    o_done_next = o_last_next && last_row;
                    off_next    = off_reg + 1'b1;
                    k_next      = k_reg + 1'b1;
                    if (!end_z)
                    begin
                        cz_next  = cz_reg + 1'b1;
                        col_next = col_reg + 1'b1;
                    end
                    else if (!end_y)
                    begin
                        cy_next   = cy_reg + 1'b1;
                        cz_next   = CUR_W'(z0);
                        col_next  = coly_reg + ROW_W'(nz);
                        coly_next = col_next;
                    end
                    else if (!end_x)
                    begin
                        cx_next   = cx_reg + 1'b1;
                        cy_next   = CUR_W'(y0);
                        cz_next   = CUR_W'(z0);
                        col_next  = colx_reg + ROW_W'(nynz_reg);
                        colx_next = col_next;
                        coly_next = col_next;
                    end
                    else
                    begin
                        // row finished: step the cursor
                        state_next = S_IDLE;
                        if (starts_reg)
                            chk_next = chk_reg + 1'b1;
                        if (last_row)
                        begin
                            rx_next  = '0;
                            ry_next  = '0;
                            rz_next  = '0;
                            off_next = '0;
                            chk_next = '0;
                        end
                        else if (DIM_W'(rz_reg) + 1'b1 < nz)
                            rz_next = rz_reg + 1'b1;
                        else
                        begin
                            rz_next = '0;
                            if (DIM_W'(ry_reg) + 1'b1 < ny)
                                ry_next = ry_reg + 1'b1;
                            else
                            begin
                                ry_next = '0;
                                rx_next = rx_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg    <= GRID_RST;
            gy_reg    <= GRID_RST;
            gz_reg    <= GRID_RST;
            cs_reg    <= CHUNK_RST;
            state_reg <= S_IDLE;
            rx_reg    <= '0;
            ry_reg    <= '0;
            rz_reg    <= '0;
            off_reg   <= '0;
            chk_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_X:     gx_reg <= cfg_data[DIM_W-1:0];
                    REG_GRID_Y:     gy_reg <= cfg_data[DIM_W-1:0];
                    REG_GRID_Z:     gz_reg <= cfg_data[DIM_W-1:0];
                    REG_CHUNK_SIZE: cs_reg <= cfg_data;
                    default:        cs_reg <= cs_reg;
                endcase
            end
            state_reg <= state_next;
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            rz_reg    <= rz_next;
            off_reg   <= off_next;
            chk_reg   <= chk_next;
            ov_reg    <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        nynz_reg   <= nynz_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        colx_reg   <= colx_next;
        coly_reg   <= coly_next;
        k_reg      <= k_next;
        starts_reg <= starts_next;
        o_row_reg  <= o_row_next;
        o_col_reg  <= o_col_next;
        o_val_reg  <= o_val_next;
        o_off_reg  <= o_off_next;
        o_cs_reg   <= o_cs_next;
        o_cn_reg   <= o_cn_next;
        o_nz_reg   <= o_nz_next;
        o_last_reg <= o_last_next;
        o_done_reg <= o_done_next;
    end

    assign ent_valid    = ov_reg;
    assign row_index    = o_row_reg;
    assign column_index = o_col_reg;
    assign entry_value  = o_val_reg;
    assign entry_offset = o_off_reg;
    assign chunk_start  = o_cs_reg;
    assign chunk_number = o_cn_reg;
    assign row_nonzeros = o_nz_reg;
    assign last_in_row  = o_last_reg;
    assign grid_done    = o_done_reg;

    // a row holds between one and 27 entries
    a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ent_valid && last_in_row) |-> (row_nonzeros != '0 && row_nonzeros <= NZ_W'(27)))
        else $error("row entry count out of range");

    // count and grid end appear only on the last entry of a row
    a_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        (ent_valid && !last_in_row) |-> (row_nonzeros == '0 && !grid_done))
        else $error("row end fields set before the last entry");

    // the remainder finishes only while the sequencer waits for it
    a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
        rstat.done |-> (state_reg == S_DIV))
        else $error("remainder result outside its wait state");

    // an accepted row blocks further requests on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req_ready)
        else $error("request taken while a row is in progress");

endmodule
